// ----- rtl/core/fvgc_pkg.sv -----
// Shared types and constants for the field vector glyph classifier.
`timescale 1ns / 1ps

package fvgc_pkg;

	// One sampled field point as it enters the block.
	typedef struct packed {
		logic signed [31:0] electric_x;
		logic signed [31:0] electric_y;
		logic signed [31:0] electric_z;
		logic signed [31:0] magnetic_x;
		logic signed [31:0] magnetic_y;
		logic signed [31:0] magnetic_z;
		logic               sample_valid;
		logic        [14:0] point_index;
	} in_item_t;

	// One glyph as it leaves the block.
	typedef struct packed {
		logic        [14:0] glyph_index;
		logic signed [15:0] direction_x;
		logic signed [15:0] direction_y;
		logic signed [15:0] direction_z;
		logic        [31:0] field_magnitude;
		logic        [31:0] glyph_length;
	} out_item_t;

	// Configuration register file contents.
	typedef struct packed {
		logic        observed_field;
		logic [1:0]  scaling_mode;
		logic [31:0] mag_floor;
		logic [31:0] mag_ceiling;
		logic [31:0] ref_mag;
		logic [31:0] visual_length;
	} cfg_t;

	// A kept point handed from the front part to the back part.
	typedef struct packed {
		logic [14:0]      index;
		logic [2:0]       neg;
		logic [2:0][31:0] abs_c;
		logic [31:0]      magnitude;
	} mid_item_t;

	// Register indexes of the configuration port.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_OBSERVED_FIELD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SCALING_MODE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAG_FLOOR      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAG_CEILING    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_REF_MAG        = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_VISUAL_LENGTH  = 3'd5;

	// Scaling mode codes.
	localparam logic [1:0] SCALE_CONSTANT = 2'd0;
	localparam logic [1:0] SCALE_LINEAR   = 2'd1;
	localparam logic [1:0] SCALE_LOG      = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [31:0] RST_MAG_CEILING   = 32'hFFFF_FFFF;
	localparam logic [31:0] RST_REF_MAG       = 32'h0001_0000;
	localparam logic [31:0] RST_VISUAL_LENGTH = 32'h0001_0000;

	// log10(2) in Q0.32.
	localparam logic [31:0] LOG10_2_Q32 = 32'h4D10_4D42;

	// Reciprocal of 50 scaled by 2^37, rounded up; exact for 32-bit operands.
	localparam logic [31:0] DIV50_RECIP = 32'd2748779070;

	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

endpackage

// ----- rtl/core/fvgc_front.sv -----
// Front part: vector select, squares, pipelined square root and drop test.
`timescale 1ns / 1ps

module fvgc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 take,
	input  fvgc_pkg::in_item_t   in_data,
	input  fvgc_pkg::cfg_t       cfg,
	output logic                 push,
	output fvgc_pkg::mid_item_t  push_data
);

	localparam int unsigned SQ_STEPS = 32;

	logic                [2:0][31:0] comp;
	logic                [2:0]       comp_neg;
	logic                            vld_s1, vld_s2, vld_s3;
	logic                            sv_s1, sv_s2, sv_s3;
	fvgc_pkg::mid_item_t             pay_s1, pay_s2, pay_s3;
	logic                [2:0][63:0] sq_s2;
	logic                [63:0]      sum_s3;

	logic                [63:0]      root_v_s   [SQ_STEPS];
	logic                [63:0]      root_r_s   [SQ_STEPS];
	logic                            root_vld_s [SQ_STEPS];
	logic                            root_sv_s  [SQ_STEPS];
	fvgc_pkg::mid_item_t             root_pay_s [SQ_STEPS];

	logic [31:0] mag;
	logic        keep;

	// Select the observed vector and split each component into sign and magnitude.
	always_comb begin
		if (cfg.observed_field) begin
			comp[0] = in_data.magnetic_x;
			comp[1] = in_data.magnetic_y;
			comp[2] = in_data.magnetic_z;
		end else begin
			comp[0] = in_data.electric_x;
			comp[1] = in_data.electric_y;
			comp[2] = in_data.electric_z;
		end
		for (int l = 0; l < 3; l++) begin
			comp_neg[l] = comp[l][31];
			if (comp[l][31]) begin
				comp[l] = ~comp[l] + 32'd1;
			end
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Capture, square each component, then sum the squares.
	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1.index     <= in_data.point_index;
			pay_s1.neg       <= comp_neg;
			pay_s1.abs_c     <= comp;
			pay_s1.magnitude <= 32'd0;
			sv_s1            <= in_data.sample_valid;
			pay_s2           <= pay_s1;
			sv_s2            <= sv_s1;
			for (int l = 0; l < 3; l++) begin
				sq_s2[l] <= 64'(pay_s1.abs_c[l]) * 64'(pay_s1.abs_c[l]);
			end
			pay_s3 <= pay_s2;
			sv_s3  <= sv_s2;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	// Square root, one result bit per stage.
	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_root
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
		logic [63:0]         v_in, r_in, trial;
		logic                vld_in, sv_in;
		fvgc_pkg::mid_item_t pay_in;

		if (j == 0) begin : g_first
			assign v_in   = sum_s3;
			assign r_in   = 64'd0;
			assign vld_in = vld_s3;
			assign sv_in  = sv_s3;
			assign pay_in = pay_s3;
		end else begin : g_next
			assign v_in   = root_v_s[j-1];
			assign r_in   = root_r_s[j-1];
			assign vld_in = root_vld_s[j-1];
			assign sv_in  = root_sv_s[j-1];
			assign pay_in = root_pay_s[j-1];
		end

		assign trial = r_in + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				root_vld_s[j] <= 1'b0;
			end else if (en) begin
				root_vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_sv_s[j]  <= sv_in;
				root_pay_s[j] <= pay_in;
				if (v_in >= trial) begin
					root_v_s[j] <= v_in - trial;
					root_r_s[j] <= (r_in >> 1) + BIT;
				end else begin
					root_v_s[j] <= v_in;
					root_r_s[j] <= r_in >> 1;
				end
			end
		end
	end

	// Drop invalid samples and magnitudes outside the window.
	assign mag  = root_r_s[SQ_STEPS-1][31:0];
	assign keep = root_sv_s[SQ_STEPS-1] && (mag > cfg.mag_floor)
		&& (mag <= cfg.mag_ceiling);
	assign push = en && root_vld_s[SQ_STEPS-1] && keep;

	always_comb begin
		push_data           = root_pay_s[SQ_STEPS-1];
		push_data.magnitude = mag;
	end

endmodule

// ----- rtl/core/fvgc_queue.sv -----
// Short queue of kept points between the front and back parts.
`timescale 1ns / 1ps

module fvgc_queue #(
	parameter int unsigned DEPTH = fvgc_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fvgc_pkg::mid_item_t push_data,
	input  logic                pop,
	output fvgc_pkg::mid_item_t head,
	output logic                full,
	output logic                empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	fvgc_pkg::mid_item_t entry_q [DEPTH];
	logic [AW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]       count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/core/fvgc_back.sv -----
// Back part: direction dividers, linear and log length, clamp and output stage.
`timescale 1ns / 1ps

module fvgc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                load,
	input  fvgc_pkg::mid_item_t head,
	input  fvgc_pkg::cfg_t      cfg,
	output logic                out_valid,
	output fvgc_pkg::out_item_t out_data
);

	localparam int unsigned DIR_Q      = 16;
	localparam int unsigned LIN_Q      = 37;
	localparam int unsigned NORM_STEPS = 6;
	localparam int unsigned LOG_STEPS  = 24;
	localparam int unsigned NB         = LIN_Q + 3;
	localparam int unsigned LAST       = NB - 1;
	localparam int unsigned DIR_DONE   = DIR_Q + 1;
	localparam int unsigned LIN_END    = LIN_Q + 1;
	localparam int unsigned SQ_FIRST   = NORM_STEPS + 1;
	localparam int unsigned SQ_LAST    = NORM_STEPS + LOG_STEPS;
	localparam int unsigned LOG_LEN    = SQ_LAST + 3;

	logic [31:0] ref_e;

	// Stage bookkeeping common to all units.
	logic        vld_s [NB];
	logic [14:0] idx_s [NB];
	logic [31:0] mag_s [NB];
	logic [2:0]  neg_s [DIR_Q+1];

	// Direction dividers.
	logic [31:0] dir_rem_s [3][DIR_Q+1];
	logic [15:0] dir_low_s [3][DIR_Q+1];
	logic [15:0] dir_s     [3][DIR_DONE:LAST];

	// Linear length divider.
	logic [63:0] lin_prod_s0;
	logic [31:0] lin_rem_s [1:LIN_END];
	logic [36:0] lin_low_s [1:LIN_END];
	logic        lin_ovf_s [1:LIN_END];

	// Log length: normalization, squaring steps, difference and scaling.
	logic [32:0] norm_w_s [2][NORM_STEPS+1];
	logic [5:0]  norm_c_s [2][NORM_STEPS+1];
	logic [30:0] sq_m_s   [2][SQ_FIRST:SQ_LAST];
	logic [23:0] sq_f_s   [2][SQ_FIRST:SQ_LAST];
	logic [5:0]  sq_c_s   [2][SQ_FIRST:SQ_LAST];
	logic [29:0] log_diff_s31;
	logic [29:0] log_g_s32;
	logic [37:0] log_len_s [LOG_LEN:LAST-1];
	logic [26:0] lo_bound_s38;

	logic [29:0] la, lb;
	logic [61:0] g_prod, len_prod;
	logic [63:0] lo_prod;
	logic [39:0] len_raw, len_min, len_clamp, hi_bound;
	logic [31:0] len_s39;

	// A zero reference acts as one.
	assign ref_e = (cfg.ref_mag == 32'd0) ? 32'd1 : cfg.ref_mag;

	// Stage zero takes the queue head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s[0]       <= head.index;
			mag_s[0]       <= head.magnitude;
			neg_s[0]       <= head.neg;
			lin_prod_s0    <= 64'(cfg.visual_length) * 64'(head.magnitude);
			norm_w_s[0][0] <= {1'b0, ref_e} + {1'b0, head.magnitude};
			norm_w_s[1][0] <= {1'b0, ref_e};
			norm_c_s[0][0] <= 6'd0;
			norm_c_s[1][0] <= 6'd0;
			for (int l = 0; l < 3; l++) begin
				{dir_rem_s[l][0], dir_low_s[l][0]} <= {1'b0, head.abs_c[l], 15'd0}
					+ {17'd0, head.magnitude[31:1]};
			end
		end
	end

	// Valid, index and magnitude travel alongside the arithmetic.
	for (genvar k = 1; k < NB; k++) begin : g_track
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				idx_s[k] <= idx_s[k-1];
				mag_s[k] <= mag_s[k-1];
			end
		end
	end

	for (genvar k = 1; k <= DIR_Q; k++) begin : g_neg
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	// Rounded direction quotient, one bit per stage, then sign and saturation.
	for (genvar l = 0; l < 3; l++) begin : g_dir
		for (genvar k = 1; k <= DIR_Q; k++) begin : g_step
			logic [32:0] trial;
			assign trial = {dir_rem_s[l][k-1], dir_low_s[l][k-1][DIR_Q-1]};

			always_ff @(posedge clk) begin
				if (en) begin
					if (trial >= {1'b0, mag_s[k-1]}) begin
						dir_rem_s[l][k] <= 32'(trial - {1'b0, mag_s[k-1]});
						dir_low_s[l][k] <= {dir_low_s[l][k-1][DIR_Q-2:0], 1'b1};
					end else begin
						dir_rem_s[l][k] <= trial[31:0];
						dir_low_s[l][k] <= {dir_low_s[l][k-1][DIR_Q-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (neg_s[DIR_Q][l]) begin
					if (dir_low_s[l][DIR_Q] > 16'h8000) begin
						dir_s[l][DIR_DONE] <= 16'h8000;
					end else begin
						dir_s[l][DIR_DONE] <= ~dir_low_s[l][DIR_Q] + 16'd1;
					end
				end else begin
					if (dir_low_s[l][DIR_Q] > 16'h7FFF) begin
						dir_s[l][DIR_DONE] <= 16'h7FFF;
					end else begin
						dir_s[l][DIR_DONE] <= dir_low_s[l][DIR_Q];
					end
				end
			end
		end

		for (genvar k = DIR_DONE + 1; k <= LAST; k++) begin : g_hold
			always_ff @(posedge clk) begin
				if (en) begin
					dir_s[l][k] <= dir_s[l][k-1];
				end
			end
		end
	end

	// Linear length: check that the quotient fits in 37 bits, then one bit per stage.
	always_ff @(posedge clk) begin
		if (en) begin
			lin_ovf_s[1] <= ({5'd0, lin_prod_s0[63:37]} >= ref_e);
			lin_rem_s[1] <= ({5'd0, lin_prod_s0[63:37]} >= ref_e) ? 32'd0
				: {5'd0, lin_prod_s0[63:37]};
			lin_low_s[1] <= lin_prod_s0[36:0];
		end
	end

	for (genvar k = 2; k <= LIN_END; k++) begin : g_lin
		logic [32:0] trial;
		assign trial = {lin_rem_s[k-1], lin_low_s[k-1][LIN_Q-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				lin_ovf_s[k] <= lin_ovf_s[k-1];
				if (trial >= {1'b0, ref_e}) begin
					lin_rem_s[k] <= 32'(trial - {1'b0, ref_e});
					lin_low_s[k] <= {lin_low_s[k-1][LIN_Q-2:0], 1'b1};
				end else begin
					lin_rem_s[k] <= trial[31:0];
					lin_low_s[k] <= {lin_low_s[k-1][LIN_Q-2:0], 1'b0};
				end
			end
		end
	end

	// Log2 of reference plus magnitude (lane 0) and of reference (lane 1).
	for (genvar l = 0; l < 2; l++) begin : g_log
		// Leading-one normalization by halving shift steps.
		for (genvar k = 1; k <= NORM_STEPS; k++) begin : g_norm
			localparam int unsigned SH = 32 >> (k - 1);

			always_ff @(posedge clk) begin
				if (en) begin
					if (norm_w_s[l][k-1][32 -: SH] == '0) begin
						norm_w_s[l][k] <= norm_w_s[l][k-1] << SH;
						norm_c_s[l][k] <= norm_c_s[l][k-1] + 6'(SH);
					end else begin
						norm_w_s[l][k] <= norm_w_s[l][k-1];
						norm_c_s[l][k] <= norm_c_s[l][k-1];
					end
				end
			end
		end

		// Repeated squaring of the mantissa, one fraction bit per stage.
		for (genvar k = SQ_FIRST; k <= SQ_LAST; k++) begin : g_sq
			logic [30:0] m_in;
			logic [23:0] f_in;
			logic [5:0]  c_in;
			logic [61:0] mm;

			if (k == SQ_FIRST) begin : g_first
				assign m_in = norm_w_s[l][NORM_STEPS][32:2];
				assign f_in = 24'd0;
				assign c_in = norm_c_s[l][NORM_STEPS];
			end else begin : g_next
				assign m_in = sq_m_s[l][k-1];
				assign f_in = sq_f_s[l][k-1];
				assign c_in = sq_c_s[l][k-1];
			end

			assign mm = 62'(m_in) * 62'(m_in);

			always_ff @(posedge clk) begin
				if (en) begin
					sq_c_s[l][k] <= c_in;
					if (mm[61]) begin
						sq_m_s[l][k] <= mm[61:31];
						sq_f_s[l][k] <= {f_in[22:0], 1'b1};
					end else begin
						sq_m_s[l][k] <= mm[60:30];
						sq_f_s[l][k] <= {f_in[22:0], 1'b0};
					end
				end
			end
		end
	end

	// Log difference, conversion to log10 and scaling by the visual length.
	assign la       = {6'd32 - sq_c_s[0][SQ_LAST], sq_f_s[0][SQ_LAST]};
	assign lb       = {6'd32 - sq_c_s[1][SQ_LAST], sq_f_s[1][SQ_LAST]};
	assign g_prod   = 62'(log_diff_s31) * 62'(fvgc_pkg::LOG10_2_Q32);
	assign len_prod = 62'(cfg.visual_length) * 62'(log_g_s32);
	assign lo_prod  = 64'(cfg.visual_length) * 64'(fvgc_pkg::DIV50_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			log_diff_s31       <= (la > lb) ? la - lb : 30'd0;
			log_g_s32          <= g_prod[61:32];
			log_len_s[LOG_LEN] <= len_prod[61:24];
			lo_bound_s38       <= lo_prod[63:37];
		end
	end

	for (genvar k = LOG_LEN + 1; k < LAST; k++) begin : g_log_hold
		always_ff @(posedge clk) begin
			if (en) begin
				log_len_s[k] <= log_len_s[k-1];
			end
		end
	end

	// Length select by mode, clamp to the visual length window, saturate.
	always_comb begin
		unique case (cfg.scaling_mode)
			fvgc_pkg::SCALE_LINEAR: begin
				len_raw = lin_ovf_s[LIN_END] ? '1 : 40'(lin_low_s[LIN_END]);
			end
			fvgc_pkg::SCALE_LOG: begin
				len_raw = 40'(log_len_s[LAST-1]);
			end
			default: begin
				len_raw = 40'(cfg.visual_length);
			end
		endcase
		hi_bound  = 40'({cfg.visual_length, 3'd0}) + 40'({cfg.visual_length, 1'b0});
		len_min   = (len_raw < 40'(lo_bound_s38)) ? 40'(lo_bound_s38) : len_raw;
		len_clamp = (len_min > hi_bound) ? hi_bound : len_min;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s39 <= (len_clamp[39:32] != 8'd0) ? 32'hFFFF_FFFF : len_clamp[31:0];
		end
	end

	// Output stage.
	assign out_valid                = vld_s[LAST];
	assign out_data.glyph_index     = idx_s[LAST];
	assign out_data.direction_x     = dir_s[0][LAST];
	assign out_data.direction_y     = dir_s[1][LAST];
	assign out_data.direction_z     = dir_s[2][LAST];
	assign out_data.field_magnitude = mag_s[LAST];
	assign out_data.glyph_length    = len_s39;

endmodule

// ----- rtl/core/field_vector_glyph_classifier_core.sv -----
// Top level of the field vector glyph classifier: config registers, front, queue, back.
// Throughput: one request per cycle while in_stall is low, set by the one-bit-per-stage square root
// in the front part and the one-bit-per-stage dividers in the back part.
// Dropped points leave no result; the queue decouples the two parts.
// Reset clears all valid flags and the queue and loads config reset values.
`timescale 1ns / 1ps

module field_vector_glyph_classifier_core #(
	parameter int unsigned QUEUE_DEPTH = fvgc_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  fvgc_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output fvgc_pkg::out_item_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fvgc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [31:0]                         cfg_data
);

	fvgc_pkg::cfg_t      cfg_q;
	fvgc_pkg::mid_item_t push_data, head;
	logic                push, pop, q_full, q_empty;
	logic                front_en, back_en;

	// Configuration registers; writes to unknown indexes are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.observed_field <= 1'b0;
			cfg_q.scaling_mode   <= fvgc_pkg::SCALE_CONSTANT;
			cfg_q.mag_floor      <= 32'd0;
			cfg_q.mag_ceiling    <= fvgc_pkg::RST_MAG_CEILING;
			cfg_q.ref_mag        <= fvgc_pkg::RST_REF_MAG;
			cfg_q.visual_length  <= fvgc_pkg::RST_VISUAL_LENGTH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fvgc_pkg::REG_OBSERVED_FIELD: cfg_q.observed_field <= cfg_data[0];
				fvgc_pkg::REG_SCALING_MODE:   cfg_q.scaling_mode <= cfg_data[1:0];
				fvgc_pkg::REG_MAG_FLOOR:      cfg_q.mag_floor <= cfg_data;
				fvgc_pkg::REG_MAG_CEILING:    cfg_q.mag_ceiling <= cfg_data;
				fvgc_pkg::REG_REF_MAG:        cfg_q.ref_mag <= cfg_data;
				fvgc_pkg::REG_VISUAL_LENGTH:  cfg_q.visual_length <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front part advances while the queue has room.
	assign front_en = !q_full;
	assign in_stall = q_full;

	// The back part advances unless its output stage holds a stalled result.
	assign back_en = !(out_valid && out_stall);
	assign pop     = back_en && !q_empty;

	fvgc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (front_en),
		.take      (in_valid && !in_stall),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.push      (push),
		.push_data (push_data)
	);

	fvgc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	fvgc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (back_en),
		.load      (pop),
		.head      (head),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
